@@ hw/rtl/ipv4_prefix_text_parser_top_assert.svh @@
`ifndef IPV4_PREFIX_TEXT_PARSER_TOP_ASSERT_SVH
`define IPV4_PREFIX_TEXT_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define IPV4P_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IPV4P_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ipv4p_pkg.sv @@
package ipv4p_pkg;

  // parse phases
  localparam logic [1:0] PH_OCTET  = 2'd0;
  localparam logic [1:0] PH_STAR   = 2'd1;
  localparam logic [1:0] PH_PREFIX = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_IPV6 = 2'd2;

  // characters of interest
  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [7:0] OCTET_MAX  = 8'd255;
  localparam logic [5:0] PREFIX_SAT = 6'd63;
  localparam logic [1:0] DIGITS_MAX = 2'd3;

  typedef struct packed {
    logic step;  // a character is consumed this cycle
    logic last;  // that character is the end-of-text byte
  } step_ctl_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] address;
    logic [5:0]  net_len;
  } result_t;

endpackage

@@ hw/rtl/ipv4p_parse.sv @@
`include "ipv4_prefix_text_parser_top_assert.svh"

module ipv4p_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ipv4p_pkg::step_ctl_t  ctl_i,
  input  logic [7:0]            char_i,
  output ipv4p_pkg::result_t    res_o
);

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  octet_value_q, octet_value_d;
  logic [1:0]  octet_digits_q, octet_digits_d;
  logic [2:0]  octets_done_q, octets_done_d;
  logic [31:0] address_q, address_d;
  logic [5:0]  prefix_q, prefix_d;
  logic        prefix_seen_q, prefix_seen_d;
  logic        malformed_q, malformed_d;
  logic        colon_q, colon_d;

  logic        is_digit;
  logic [3:0]  digit;
  logic [11:0] octet_next;
  logic [9:0]  prefix_next;
  logic        close_ok;
  logic [4:0]  close_shift;
  logic [31:0] address_closed;
  logic        ok;
  logic [5:0]  plen;
  logic [31:0] addr_final;
  logic [31:0] mask;

  assign is_digit    = (char_i >= ipv4p_pkg::CH_ZERO) && (char_i <= ipv4p_pkg::CH_NINE);
  assign digit       = 4'(char_i - ipv4p_pkg::CH_ZERO);
  assign octet_next  = {4'd0, octet_value_q} * 12'd10 + {8'd0, digit};
  assign prefix_next = {4'd0, prefix_q} * 10'd10 + {6'd0, digit};
  // octet lands at byte 3 - octets_done (only used when fewer than four done)
  assign close_ok       = (octet_digits_q != 2'd0) && (octets_done_q < 3'd4);
  assign close_shift    = {~octets_done_q[1:0], 3'b000};
  assign address_closed = address_q | ({24'd0, octet_value_q} << close_shift);

  always_comb begin
    phase_d        = phase_q;
    octet_value_d  = octet_value_q;
    octet_digits_d = octet_digits_q;
    octets_done_d  = octets_done_q;
    address_d      = address_q;
    prefix_d       = prefix_q;
    prefix_seen_d  = prefix_seen_q;
    malformed_d    = malformed_q;
    colon_d        = colon_q;
    ok             = !malformed_q;
    plen           = 6'd0;
    addr_final     = address_q;

    if (char_i == ipv4p_pkg::CH_COLON) begin
      colon_d = 1'b1;
    end

    if (!ctl_i.last) begin
      if (!malformed_q) begin
        case (phase_q)
          ipv4p_pkg::PH_OCTET: begin
            if (is_digit) begin
              if (octet_digits_q >= ipv4p_pkg::DIGITS_MAX ||
                  octet_next > {4'd0, ipv4p_pkg::OCTET_MAX}) begin
                malformed_d = 1'b1;
              end else begin
                octet_value_d  = octet_next[7:0];
                octet_digits_d = octet_digits_q + 2'd1;
              end
            end else if (char_i == ipv4p_pkg::CH_STAR && octet_digits_q == 2'd0 &&
                         octets_done_q != 3'd0) begin
              phase_d = ipv4p_pkg::PH_STAR;
            end else if (char_i == ipv4p_pkg::CH_DOT) begin
              // a dot may not close the fourth octet
              if (!close_ok || octets_done_q >= 3'd3) begin
                malformed_d = 1'b1;
              end else begin
                address_d      = address_closed;
                octets_done_d  = octets_done_q + 3'd1;
                octet_value_d  = 8'd0;
                octet_digits_d = 2'd0;
              end
            end else if (char_i == ipv4p_pkg::CH_SLASH) begin
              if (!close_ok || octets_done_q == 3'd0) begin
                malformed_d = 1'b1;
              end else begin
                address_d      = address_closed;
                octets_done_d  = octets_done_q + 3'd1;
                octet_value_d  = 8'd0;
                octet_digits_d = 2'd0;
                phase_d        = ipv4p_pkg::PH_PREFIX;
              end
            end else begin
              malformed_d = 1'b1;
            end
          end
          ipv4p_pkg::PH_PREFIX: begin
            if (is_digit) begin
              prefix_d      = (prefix_next > {4'd0, ipv4p_pkg::PREFIX_SAT}) ?
                              ipv4p_pkg::PREFIX_SAT : prefix_next[5:0];
              prefix_seen_d = 1'b1;
            end else begin
              malformed_d = 1'b1;
            end
          end
          default: begin
            malformed_d = 1'b1;
          end
        endcase
      end
    end else begin
      // end of text: finish the result, then return to the start state
      case (phase_q)
        ipv4p_pkg::PH_OCTET: begin
          addr_final = address_closed;
          if (!close_ok || octets_done_q == 3'd0) begin
            ok = 1'b0;
          end else begin
            plen = {octets_done_q + 3'd1, 3'b000};
          end
        end
        ipv4p_pkg::PH_STAR: begin
          plen = {octets_done_q, 3'b000};
        end
        default: begin
          if (!prefix_seen_q || prefix_q > {octets_done_q, 3'b000}) begin
            ok = 1'b0;
          end else begin
            plen = prefix_q;
          end
        end
      endcase

      phase_d        = ipv4p_pkg::PH_OCTET;
      octet_value_d  = 8'd0;
      octet_digits_d = 2'd0;
      octets_done_d  = 3'd0;
      address_d      = 32'd0;
      prefix_d       = 6'd0;
      prefix_seen_d  = 1'b0;
      malformed_d    = 1'b0;
      colon_d        = 1'b0;
    end
  end

  assign mask = ~(32'hFFFF_FFFF >> plen);

  always_comb begin
    if (colon_q) begin
      res_o.status  = ipv4p_pkg::ST_IPV6;
      res_o.address = 32'd0;
      res_o.net_len = 6'd0;
    end else if (!ok) begin
      res_o.status  = ipv4p_pkg::ST_BAD;
      res_o.address = 32'd0;
      res_o.net_len = 6'd0;
    end else begin
      res_o.status  = ipv4p_pkg::ST_OK;
      res_o.address = addr_final & mask;
      res_o.net_len = plen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= ipv4p_pkg::PH_OCTET;
      octet_value_q  <= 8'd0;
      octet_digits_q <= 2'd0;
      octets_done_q  <= 3'd0;
      address_q      <= 32'd0;
      prefix_q       <= 6'd0;
      prefix_seen_q  <= 1'b0;
      malformed_q    <= 1'b0;
      colon_q        <= 1'b0;
    end else if (ctl_i.step) begin
      phase_q        <= phase_d;
      octet_value_q  <= octet_value_d;
      octet_digits_q <= octet_digits_d;
      octets_done_q  <= octets_done_d;
      address_q      <= address_d;
      prefix_q       <= prefix_d;
      prefix_seen_q  <= prefix_seen_d;
      malformed_q    <= malformed_d;
      colon_q        <= colon_d;
    end
  end

  `IPV4P_ASSERT_IMP(a_octet_idle_outside_digits, clk_i, rst_ni,
    phase_q != ipv4p_pkg::PH_OCTET, octet_digits_q == 2'd0 && octet_value_q == 8'd0,
    "octet accumulator busy outside octet phase")
  `IPV4P_ASSERT_NXT(a_clear_after_end, clk_i, rst_ni, ctl_i.step && ctl_i.last,
    octets_done_q == 3'd0 && !malformed_q && !colon_q && phase_q == ipv4p_pkg::PH_OCTET,
    "parser state not cleared after end of text")
  `IPV4P_ASSERT_NXT(a_malformed_sticks, clk_i, rst_ni,
    malformed_q && !(ctl_i.step && ctl_i.last), malformed_q,
    "malformed flag dropped before end of text")

endmodule

@@ hw/rtl/ipv4p_obuf.sv @@
module ipv4p_obuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  ipv4p_pkg::result_t res_i,
  input  logic               stall_i,
  output logic               valid_o,
  output ipv4p_pkg::result_t res_o
);

  logic               valid_q;
  ipv4p_pkg::result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload only moves on a load, so a stalled word holds
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ hw/rtl/ipv4_prefix_text_parser_top.sv @@
// IPv4 prefix text parser. Feed one text byte per word on char_code_i; a zero byte ends the
// text and yields one result word (status, masked address, prefix length); other bytes yield
// nothing. Accepts dotted decimal with 2 to 4 octets, optionally ending in "/len", or with 1
// to 3 octets ending in ".*"; a colon anywhere reports the IPv6 form. Throughput is one byte
// per cycle while the input is not stalled: each byte is registered at the input, folded into
// the parse state by one pass of logic when it advances, and on the end byte the result is
// registered at that same edge, so the result word is valid from the cycle after its end byte
// is taken. The input stalls only while an end byte waits on a full, stalled output register;
// ordinary bytes keep flowing under an output stall.

`include "ipv4_prefix_text_parser_top_assert.svh"

module ipv4_prefix_text_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  char_code_i,
  // result channel
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] address_o,
  output logic [5:0]  net_len_o
);

  logic                 in_valid_q;
  logic [7:0]           char_q;
  logic                 is_end;
  logic                 out_valid;
  logic                 out_free;
  logic                 advance;
  ipv4p_pkg::step_ctl_t ctl;
  ipv4p_pkg::result_t   res_next;
  ipv4p_pkg::result_t   res_out;

  assign is_end   = (char_q == ipv4p_pkg::CH_END);
  assign out_free = !out_valid || !stall_i;
  // an end byte needs room in the output register; other bytes never wait
  assign advance  = in_valid_q && (!is_end || out_free);
  assign stall_o  = in_valid_q && !advance;

  assign ctl.step = advance;
  assign ctl.last = is_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!stall_o) begin
      in_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      char_q <= char_code_i;
    end
  end

  ipv4p_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .char_i (char_q),
    .res_o  (res_next)
  );

  ipv4p_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && is_end),
    .res_i   (res_next),
    .stall_i (stall_i),
    .valid_o (out_valid),
    .res_o   (res_out)
  );

  assign valid_o   = out_valid;
  assign status_o  = res_out.status;
  assign address_o = res_out.address;
  assign net_len_o = res_out.net_len;

  `IPV4P_ASSERT_IMP(a_stall_only_on_end, clk_i, rst_ni, stall_o,
    in_valid_q && is_end && out_valid && stall_i,
    "input stalled without a blocked end byte")
  `IPV4P_ASSERT_NXT(a_held_byte_kept, clk_i, rst_ni, stall_o,
    in_valid_q && $stable(char_q), "stalled input byte lost")
  `IPV4P_ASSERT_NXT(a_result_needs_end, clk_i, rst_ni,
    !out_valid && !(advance && is_end), !out_valid,
    "result word raised without an end byte")

endmodule
